// ===== sv/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants for the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS = 30;

  localparam logic signed [39:0] TWO_PI_Q28  = 40'sd1686629713;
  localparam logic signed [39:0] PI_Q28      = 40'sd843314857;
  localparam logic signed [39:0] HALF_PI_Q28 = 40'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  localparam logic [31:0] TICK_LENGTH_RST    = 32'd1283804;
  localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd57852468;

  localparam logic [0:0] REG_TICK_LENGTH    = 1'b0;
  localparam logic [0:0] REG_INV_WHEEL_BASE = 1'b1;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 32'h3243F6A8;
      5'd1: atan_q30 = 32'h1DAC6705;
      5'd2: atan_q30 = 32'h0FADBAFC;
      5'd3: atan_q30 = 32'h07F56EA6;
      5'd4: atan_q30 = 32'h03FEAB76;
      5'd5: atan_q30 = 32'h01FFD55B;
      5'd6: atan_q30 = 32'h00FFFAAA;
      5'd7: atan_q30 = 32'h007FFF55;
      5'd8: atan_q30 = 32'h003FFFEA;
      5'd9: atan_q30 = 32'h001FFFFD;
      default: atan_q30 = (32'h1 << (5'd30 - i)) - 32'd1;
    endcase
  endfunction

endpackage

// ===== sv/ddo_if.sv =====
// ----------------------------------------------------------------------------
// ddo_in_if / ddo_out_if
// Valid/ready channels carrying wheel counts and pose results.
// ----------------------------------------------------------------------------
interface ddo_in_if #(parameter int COUNT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] left_ticks;
  logic [COUNT_BITS-1:0] right_ticks;
  modport source (output valid, left_ticks, right_ticks, input ready);
  modport sink   (input valid, left_ticks, right_ticks, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

// ===== sv/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q4.30.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,   // Q4.28
  output logic               done,
  output logic signed [33:0] cos_o,   // Q4.30, clamped
  output logic signed [33:0] sin_o
);

  logic signed [35:0] x_r, y_r, z_r;
  logic [4:0]  i_r;
  logic        busy_r, neg_r, done_r;
  logic signed [39:0] a0, a1;
  logic               fold;
  logic signed [35:0] dx, dy, at;
  logic signed [35:0] xc, yc;

  always_comb begin
    a0 = 40'(angle);
    if (a0 > ddo_pkg::PI_Q28) a0 = a0 - ddo_pkg::TWO_PI_Q28;
    else if (a0 < -ddo_pkg::PI_Q28) a0 = a0 + ddo_pkg::TWO_PI_Q28;
    fold = 1'b0;
    a1 = a0;
    if (a0 > ddo_pkg::HALF_PI_Q28) begin
      a1 = a0 - ddo_pkg::PI_Q28; fold = 1'b1;
    end else if (a0 < -ddo_pkg::HALF_PI_Q28) begin
      a1 = a0 + ddo_pkg::PI_Q28; fold = 1'b1;
    end
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = 36'(ddo_pkg::atan_q30(i_r));
    xc = x_r;
    if (xc > 36'(ddo_pkg::ONE_Q30)) xc = 36'(ddo_pkg::ONE_Q30);
    if (xc < -36'(ddo_pkg::ONE_Q30)) xc = -36'(ddo_pkg::ONE_Q30);
    yc = y_r;
    if (yc > 36'(ddo_pkg::ONE_Q30)) yc = 36'(ddo_pkg::ONE_Q30);
    if (yc < -36'(ddo_pkg::ONE_Q30)) yc = -36'(ddo_pkg::ONE_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        neg_r  <= fold;
        x_r    <= 36'(ddo_pkg::CORDIC_GAIN);
        y_r    <= '0;
        z_r    <= 36'(a1 * 4);
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end
        if (i_r == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 5'd1;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = neg_r ? -34'(xc) : 34'(xc);
  assign sin_o = neg_r ? -34'(yc) : 34'(yc);

endmodule

// ===== sv/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Pose integration from wheel encoder counts, fixed point.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel carries left and right encoder
// counts for one update period. The block scales them by tick_length, runs a
// 30-step CORDIC on the previous heading, and moves x/y by the mean distance
// along cos/sin; the heading is advanced by the wheel difference times
// inv_wheel_base and wrapped once by 2*pi.
// After acceptance a request uses the one shared 32x32 multiplier for two
// wheel distances and the heading step, waits for the CORDIC iterations
// started with the first product, then uses it for two position steps. in
// ready is low while an item is in flight, so no new request is taken until
// the last is through. A new request may be taken while the previous result
// waits in the output register; it then holds in its last step until that
// register frees, so a stalled receiver simply holds the pose until taken.
// Reset clears the pose to zero and loads the default register values.
// Registers: 0x0 tick_length, 0x4 inv_wheel_base, written over the APB port.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_DL, S_DR, S_MEAN, S_DTH, S_CORDIC, S_MX, S_MY, S_UPD, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] tick_r, invwb_r;
  logic [31:0] lc_r, rc_r;
  logic [63:0] dl_r, dr_r, prod_r;
  logic [31:0] mean_r, diff_r;
  logic        tneg_r;
  logic signed [41:0] dth_r;
  logic signed [31:0] x_r, y_r, th_r;
  logic signed [33:0] c_r, s_r;
  logic signed [31:0] ox_r, oy_r, oth_r;
  logic        ovalid_r;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic        cstart, cdone;
  logic signed [33:0] cos_w, sin_w;
  logic [63:0] mean64, dif64;
  logic [40:0] dmag;
  logic signed [33:0] trig;
  logic [33:0] tmag;
  logic signed [34:0] pstep;
  logic signed [33:0] pos_sum;
  logic signed [42:0] th_sum;

  function automatic logic [31:0] to_q16(input logic [63:0] v);
    logic [48:0] r;
    r = 49'(v[63:16]) + 49'(v[15]);
    to_q16 = (r > 49'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
  endfunction

  function automatic logic [31:0] sat_cnt(input logic [COUNT_BITS-1:0] c);
    sat_cnt = 32'(c);
  endfunction

  // shared 32x32 multiplier
  always_comb begin
    ma = tick_r; mb = lc_r;
    tmag = '0;
    trig = c_r;
    case (state_r) inside
      S_DR:  mb = rc_r;
      S_DTH: begin ma = diff_r; mb = invwb_r; end
      S_MX, S_MY: begin
        trig = (state_r == S_MX) ? c_r : s_r;
        tmag = trig[33] ? 34'(-trig) : 34'(trig);
        ma = mean_r; mb = tmag[31:0];
        if (tmag[30]) mb = 32'h40000000;
      end
      default: ;
    endcase
    mp = ma * mb;
    mean64 = (dl_r >> 1) + (dr_r >> 1) + 64'(dl_r[0] & dr_r[0]);
    dif64  = (dr_r < dl_r) ? dl_r - dr_r : dr_r - dl_r;
    dmag = 41'(prod_r[63:12]) + 41'(prod_r[11]);
    if (prod_r[63:12] >= 52'h10000000000) dmag = 41'h10000000000;
  end

  // position step from prod_r (taken in the cycle after the multiply)
  logic sgn_r;
  logic signed [31:0] pos_cur;
  always_comb begin
    pstep = 35'((prod_r + 64'h20000000) >> 30);
    if (sgn_r) pstep = -pstep;
    pos_cur = (state_r == S_MY) ? x_r : y_r;
    pos_sum = 34'(pos_cur) + 34'(pstep);
    th_sum = 43'(th_r) + 43'(dth_r);
    if (th_sum < -43'(ddo_pkg::TWO_PI_Q28)) th_sum = th_sum + 43'(ddo_pkg::TWO_PI_Q28);
    else if (th_sum > 43'(ddo_pkg::TWO_PI_Q28)) th_sum = th_sum - 43'(ddo_pkg::TWO_PI_Q28);
  end

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -43'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  assign cstart = (state_r == S_DL);

  ddo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(th_r),
    .done(cdone), .cos_o(cos_w), .sin_o(sin_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tick_r   <= ddo_pkg::TICK_LENGTH_RST;
      invwb_r  <= ddo_pkg::INV_WHEEL_BASE_RST;
      x_r <= '0; y_r <= '0; th_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
        if (cfg_paddr[2] == ddo_pkg::REG_TICK_LENGTH) tick_r <= cfg_pwdata;
        else invwb_r <= cfg_pwdata;
      end
      // in S_OUT the output register is reloaded or held below
      if (ovalid_r && out_ch.ready && state_r != S_OUT) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          lc_r <= sat_cnt(in_ch.left_ticks);
          rc_r <= sat_cnt(in_ch.right_ticks);
          state_r <= S_DL;
        end
        S_DL:  begin dl_r <= mp; state_r <= S_DR; end
        S_DR:  begin dr_r <= mp; state_r <= S_MEAN; end
        S_MEAN: begin
          mean_r <= to_q16(mean64);
          diff_r <= to_q16(dif64);
          tneg_r <= dr_r < dl_r;
          state_r <= S_DTH;
        end
        S_DTH: begin prod_r <= mp; state_r <= S_CORDIC; end
        S_CORDIC: begin
          dth_r <= tneg_r ? -42'(dmag) : 42'(dmag);
          if (cdone) begin
            c_r <= cos_w; s_r <= sin_w;
            state_r <= S_MX;
          end
        end
        S_MX: begin
          prod_r <= mp; sgn_r <= c_r[33]; state_r <= S_MY;
        end
        S_MY: begin
          x_r <= sat32(43'(pos_sum));
          prod_r <= mp; sgn_r <= s_r[33]; state_r <= S_UPD;
        end
        S_UPD: begin
          y_r  <= sat32(43'(pos_sum));
          th_r <= sat32(th_sum);
          state_r <= S_OUT;
        end
        S_OUT: if (!ovalid_r || out_ch.ready) begin
          ox_r <= x_r; oy_r <= y_r; oth_r <= th_r;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = ovalid_r;
  assign out_ch.pos_x   = ox_r;
  assign out_ch.pos_y   = oy_r;
  assign out_ch.heading = oth_r;
  assign cfg_pready     = 1'b1;
  assign cfg_prdata     = cfg_paddr[2] ? invwb_r : tick_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cstart |-> $past(state_r) == S_IDLE) else $error("cordic start out of order");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> ovalid_r) else $error("result dropped");
  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cdone |-> state_r == S_CORDIC) else $error("cordic done unexpected");

endmodule

// ===== verif/differential_drive_odometry_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Drives wheel counts and register settings into the odometry block and checks
// every pose against an in-bench fixed-point predictor of the pose update.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;

  localparam int CNT_W = 16;
  localparam int IDLE_WAIT = 60;
  localparam int WDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hd;
  } pose_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  ddo_in_if #(.COUNT_BITS(CNT_W)) in_ch ();
  ddo_out_if out_ch ();

  differential_drive_odometry #(.COUNT_BITS(CNT_W)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [31:0] tick_len_m, inv_base_m;
  longint      x_m, y_m, th_m;
  pose_t       pose_q[$];

  int  n_err;
  int  idle_cycles;
  bit  hold_off;
  bit  hold_done;
  int  hold_left;
  int  stall_left;

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > longint'(ddo_pkg::ONE_Q30)) return longint'(ddo_pkg::ONE_Q30);
    if (v < -longint'(ddo_pkg::ONE_Q30)) return -longint'(ddo_pkg::ONE_Q30);
    return v;
  endfunction

  function automatic longint unsigned round_q16(longint unsigned v);
    longint unsigned r;
    r = (v >> 16) + ((v >> 15) & 1);
    return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
  endfunction

  function automatic void heading_trig(longint ang, output longint c, output longint s);
    bit     flip;
    longint xv, yv, zv, dx, dy;
    longint atn[30];
    atn = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001};
    flip = 1'b0;
    xv = longint'(ddo_pkg::CORDIC_GAIN);
    yv = 0;
    if (ang > longint'(ddo_pkg::PI_Q28)) ang -= longint'(ddo_pkg::TWO_PI_Q28);
    else if (ang < -longint'(ddo_pkg::PI_Q28)) ang += longint'(ddo_pkg::TWO_PI_Q28);
    if (ang > longint'(ddo_pkg::HALF_PI_Q28)) begin
      ang -= longint'(ddo_pkg::PI_Q28); flip = 1'b1;
    end else if (ang < -longint'(ddo_pkg::HALF_PI_Q28)) begin
      ang += longint'(ddo_pkg::PI_Q28); flip = 1'b1;
    end
    zv = ang * 4;
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (zv >= 0) begin
        xv -= dx; yv += dy; zv -= atn[i];
      end else begin
        xv += dx; yv -= dy; zv += atn[i];
      end
    end
    xv = unit_clamp(xv);
    yv = unit_clamp(yv);
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endfunction

  function automatic longint move_step(longint unsigned mean, longint trig);
    longint unsigned mag;
    longint          d;
    mag = (trig < 0) ? longint'(-trig) : trig;
    d = longint'((mean * mag + (64'd1 << 29)) >> 30);
    return (trig < 0) ? -d : d;
  endfunction

  function automatic pose_t advance_pose(logic [CNT_W-1:0] lt, logic [CNT_W-1:0] rt);
    longint unsigned dl, dr, mean, mean16, diff16, prod, dmag;
    longint          dth, th, c, s;
    bit              neg_turn;
    pose_t           p;
    dl = longint'(lt) * tick_len_m;
    dr = longint'(rt) * tick_len_m;
    mean = (dl >> 1) + (dr >> 1) + (dl & dr & 1);
    mean16 = round_q16(mean);
    neg_turn = dr < dl;
    diff16 = round_q16(neg_turn ? dl - dr : dr - dl);
    prod = diff16 * inv_base_m;
    dmag = (prod >> 12) + ((prod >> 11) & 1);
    if (dmag > (64'd1 << 40)) dmag = 64'd1 << 40;
    dth = neg_turn ? -longint'(dmag) : longint'(dmag);
    heading_trig(th_m, c, s);
    x_m = sat_s32(x_m + move_step(mean16, c));
    y_m = sat_s32(y_m + move_step(mean16, s));
    th = th_m + dth;
    if (th < -longint'(ddo_pkg::TWO_PI_Q28)) th += longint'(ddo_pkg::TWO_PI_Q28);
    else if (th > longint'(ddo_pkg::TWO_PI_Q28)) th -= longint'(ddo_pkg::TWO_PI_Q28);
    th_m = sat_s32(th);
    p.px = x_m[31:0]; p.py = y_m[31:0]; p.hd = th_m[31:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t",
             what, $signed(got), $signed(want), $realtime);
    n_err++;
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // one request on the input channel; valid stays up for a back to back request
  task automatic send_counts(logic [CNT_W-1:0] lt, logic [CNT_W-1:0] rt, bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_ticks <= lt;
    in_ch.right_ticks <= rt;
    do @(posedge clk); while (!in_ch.ready);
    pose_q.push_back(advance_pose(lt, rt));
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == {ddo_pkg::REG_TICK_LENGTH, 2'b00}) tick_len_m = val;
    else inv_base_m = val;
  endtask

  task automatic drain_and_wait();
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] tl, logic [31:0] iwb);
    drain_and_wait();
    write_reg({ddo_pkg::REG_TICK_LENGTH, 2'b00}, tl);
    write_reg({ddo_pkg::REG_INV_WHEEL_BASE, 2'b00}, iwb);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic random_counts(int n, bit small_only);
    logic [CNT_W-1:0] lt, rt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin lt = CNT_W'($urandom); rt = CNT_W'($urandom); end
        1: begin
          lt = CNT_W'($urandom_range(0, 200));
          rt = CNT_W'(lt + $urandom_range(0, 8));
        end
        2: begin lt = {CNT_W{1'b1}}; rt = CNT_W'($urandom_range(0, 3)); end
        default: begin
          lt = CNT_W'($urandom_range(0, 400));
          rt = CNT_W'($urandom_range(0, 400));
        end
      endcase
      if (small_only) begin lt = CNT_W'(lt % 64); rt = CNT_W'(rt % 64); end
      send_counts(lt, rt, 1'b1);
    end
  endtask

  task automatic test_directed();
    send_counts('0, '0, 1'b0);
    send_counts({CNT_W{1'b1}}, {CNT_W{1'b1}}, 1'b0);
    send_counts({CNT_W{1'b1}}, '0, 1'b0);
    send_counts('0, {CNT_W{1'b1}}, 1'b0);
    send_counts(16'h5555, 16'hAAAA, 1'b0);
    send_counts(16'hAAAA, 16'h5555, 1'b0);
    send_counts(CNT_W'(1), '0, 1'b0);
    send_counts('0, CNT_W'(1), 1'b0);
    // full-scale tick length and base: clamped heading step, wraps, saturating x/y
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_counts({CNT_W{1'b1}}, '0, 1'b0);
    for (int i = 0; i < 6; i++) send_counts('0, {CNT_W{1'b1}}, 1'b0);
    send_counts({CNT_W{1'b1}}, {CNT_W{1'b1}}, 1'b0);
    set_regs('0, '0);
    send_counts({CNT_W{1'b1}}, 16'h1234, 1'b0);
  endtask

  task automatic test_default_regs();
    set_regs(ddo_pkg::TICK_LENGTH_RST, ddo_pkg::INV_WHEEL_BASE_RST);
    random_counts(400, 1'b0);
  endtask

  task automatic test_random_regs();
    for (int k = 0; k < 4; k++) begin
      set_regs($urandom, $urandom);
      random_counts(100, 1'b0);
    end
    set_regs(32'h0100_0000, 32'hFFFF_FFFF);
    random_counts(100, 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_regs($urandom_range(1, 32'h00FF_FFFF), $urandom);
    hold_off = 1'b1;
    random_counts(20, 1'b1);
    random_counts(250, 1'b0);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      stall_left <= 0;
    end else if (hold_off && !hold_done) begin
      out_ch.ready <= 1'b0;
      if (hold_left == HOLD_CYCLES) hold_done <= 1'b1;
      else hold_left <= hold_left + 1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) stall_left <= rand_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        $display("unexpected pose at %0t", $realtime);
        n_err++;
      end else begin
        w = pose_q.pop_front();
        if (out_ch.pos_x !== w.px) report_mismatch("pos_x", out_ch.pos_x, w.px);
        if (out_ch.pos_y !== w.py) report_mismatch("pos_y", out_ch.pos_y, w.py);
        if (out_ch.heading !== w.hd) report_mismatch("heading", out_ch.heading, w.hd);
      end
    end
  end

  // watchdog on cycles without any accepted request, taken result or register access
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.left_ticks = '0; in_ch.right_ticks = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    tick_len_m = ddo_pkg::TICK_LENGTH_RST; inv_base_m = ddo_pkg::INV_WHEEL_BASE_RST;
    x_m = 0; y_m = 0; th_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_regs();
    test_random_regs();
    test_output_backpressure();
    drain_and_wait();
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ddo_pkg.sv
sv/ddo_if.sv
sv/ddo_cordic.sv
sv/differential_drive_odometry.sv
verif/differential_drive_odometry_tb.sv
